### hdl/ttacc_pkg.sv
// ttacc_pkg: shared types, widths and codes of the tangent accumulator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package ttacc_pkg;

  // vertex store geometry
  localparam int VERTEX_COUNT = 1024;
  localparam int VIDX_W       = 10;
  localparam int VADDR_W      = $clog2(VERTEX_COUNT);

  // fixed point widths
  localparam int COORD_W = 32;              // Q16.16 input value
  localparam int DIFF_W  = COORD_W + 1;     // exact edge / uv delta
  localparam int PROD_W  = 2 * DIFF_W;      // full product
  localparam int ACC_W   = PROD_W + 1;      // difference of two products
  localparam int MAG_W   = ACC_W - 1;       // magnitude of a vector component
  localparam int TOP_W   = 30;              // significant bits kept for the length
  localparam int SQ_W    = 2 * TOP_W;
  localparam int RAD_W   = SQ_W + 2;        // sum of three squares
  localparam int ROOT_W  = RAD_W + 1;       // square root working register
  localparam int ROOT_STEPS = RAD_W / 2 + 1;
  localparam int LEN_W   = RAD_W / 2;
  localparam int QUO_W   = 15;              // normalized magnitude, at most 2^14
  localparam int FRAC_SH = 15;
  localparam int NUM_W   = TOP_W + FRAC_SH + 1;
  localparam int VEC_W   = 16;              // Q2.14 output
  localparam int SUM_W   = VEC_W + 1;
  localparam int MEM_W   = 6 * VEC_W;
  localparam int MUL_STEPS = 14;

  // request queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // field codes
  localparam logic       REQ_READ    = 1'b1;
  localparam logic [1:0] CORNER_LAST = 2'd2;
  localparam logic [1:0] CORNER_VOID = 2'd3;

  typedef enum logic [1:0] {
    CMD_READ,
    CMD_CORNER,
    CMD_TRIANGLE
  } cmd_e;

  typedef struct packed {
    cmd_e                     cmd;
    logic [1:0]               corner;
    logic [VIDX_W-1:0]        idx;
    logic [2:0][COORD_W-1:0]  pos;
    logic [1:0][COORD_W-1:0]  uv;
  } entry_t;

  typedef logic [2:0][VEC_W-1:0] vec3_t;

  typedef struct packed {
    logic                   start;
    logic [2:0][MAG_W-1:0]  mag;
    logic [2:0]             neg;
  } norm_req_t;

  typedef struct packed {
    logic  done;
    vec3_t vec;
  } norm_rsp_t;

  typedef struct packed {
    vec3_t tangent;
    vec3_t binormal;
    logic  degenerate;
  } result_t;

  typedef enum logic [2:0] {
    N_IDLE,
    N_ALIGN,
    N_SQ,
    N_SUM,
    N_SQRT,
    N_DLOAD,
    N_DIV
  } norm_state_e;

  typedef enum logic [3:0] {
    B_CLEAR,
    B_IDLE,
    B_READ_OUT,
    B_MUL,
    B_CHECK,
    B_NORM_T,
    B_NORM_B,
    B_VTX,
    B_VTX_CHK,
    B_SUM_T,
    B_SUM_B
  } back_state_e;

  // vertex index inside the store
  function automatic logic idx_valid(logic [VIDX_W-1:0] idx);
    return 32'(idx) < VERTEX_COUNT;
  endfunction

endpackage

### hdl/triangle_tangent_accumulator_unit.sv
// A read passes the staging register, the queue, the store read and the result register;
// a corner passes the staging register and the queue to the back end. Throughput: one
// request a cycle while the staging register and 2-entry queue have room; corner 2 holds
// the back end through the products and, unless degenerate, 2 to 8 normalizer passes (a
// zero vector needs no iteration). Reset: control clears at once; the vertex store is then
// cleared one entry a cycle, all 1024 entries, with in_stall_o held high.
`timescale 1ns / 1ps

module triangle_tangent_accumulator_unit import ttacc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                req_type_i,
  input  logic [1:0]          corner_i,
  input  logic [VIDX_W-1:0]   vertex_index_i,
  input  logic signed [31:0]  pos_x_i,
  input  logic signed [31:0]  pos_y_i,
  input  logic signed [31:0]  pos_z_i,
  input  logic signed [31:0]  tex_u_i,
  input  logic signed [31:0]  tex_v_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [15:0]  tangent_x_o,
  output logic signed [15:0]  tangent_y_o,
  output logic signed [15:0]  tangent_z_o,
  output logic signed [15:0]  binormal_x_o,
  output logic signed [15:0]  binormal_y_o,
  output logic signed [15:0]  binormal_z_o,
  output logic                degenerate_seen_o
);

  logic    busy, q_full, push, pop, q_valid;
  entry_t  f_entry, q_head;
  result_t result;

  // request intake
  ttacc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .corner_i       (corner_i),
    .vertex_index_i (vertex_index_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .pos_z_i        (pos_z_i),
    .tex_u_i        (tex_u_i),
    .tex_v_i        (tex_v_i),
    .busy_i         (busy),
    .q_full_i       (q_full),
    .push_o         (push),
    .entry_o        (f_entry)
  );

  // decoupling queue
  ttacc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (f_entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  // triangle engine and store
  ttacc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .head_i      (q_head),
    .pop_o       (pop),
    .clearing_o  (busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result)
  );

  assign tangent_x_o       = result.tangent[0];
  assign tangent_y_o       = result.tangent[1];
  assign tangent_z_o       = result.tangent[2];
  assign binormal_x_o      = result.binormal[0];
  assign binormal_y_o      = result.binormal[1];
  assign binormal_z_o      = result.binormal[2];
  assign degenerate_seen_o = result.degenerate;

endmodule

### hdl/ttacc_norm.sv
// ttacc_norm: iterative vector normalizer to Q2.14
// alignment shifter, bit-pair square root, restoring divider; uses ttacc_pkg
`timescale 1ns / 1ps

module ttacc_norm import ttacc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  norm_req_t req_i,
  output norm_rsp_t rsp_o
);

  norm_state_e state_q, state_d;

  logic [2:0][MAG_W-1:0] m_q;
  logic [2:0]            neg_q;
  logic [2:0][SQ_W-1:0]  sq_q;
  logic [RAD_W-1:0]      x_q;
  logic [ROOT_W-1:0]     res_q;
  logic [4:0]            k_q;
  logic [1:0]            comp_q;
  logic [31:0]           rem_q;
  logic [FRAC_SH-1:0]    low_q;
  logic [QUO_W-1:0]      quo_q;
  logic [3:0]            dcnt_q;
  vec3_t                 vec_q;
  logic                  done_q;

  logic [MAG_W-1:0]  orv;
  logic              all_zero;
  logic [ROOT_W-1:0] bitv;
  logic [63:0]       trial;
  logic              take;
  logic [LEN_W-1:0]  len;
  logic [TOP_W-1:0]  mtop;
  logic [NUM_W-1:0]  num;
  logic [32:0]       dtrial;
  logic [32:0]       dvsr;
  logic              ge;
  logic [QUO_W-1:0]  qfin;
  logic [VEC_W-1:0]  qext;

  // shared datapath terms
  always_comb begin
    orv      = m_q[0] | m_q[1] | m_q[2];
    all_zero = (req_i.mag[0] == '0) && (req_i.mag[1] == '0) && (req_i.mag[2] == '0);
    bitv     = ROOT_W'(1) << {k_q, 1'b0};
    trial    = 64'(res_q) + 64'(bitv);
    take     = 64'(x_q) >= trial;
    len      = res_q[LEN_W-1:0];
    mtop     = m_q[comp_q][MAG_W-1 -: TOP_W];
    num      = {mtop, {FRAC_SH{1'b0}}} + NUM_W'(len);
    dtrial   = {rem_q, low_q[FRAC_SH-1]};
    dvsr     = 33'({len, 1'b0});
    ge       = dtrial >= dvsr;
    qfin     = {quo_q[QUO_W-2:0], ge};
    qext     = {1'b0, qfin};
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      N_IDLE:  if (req_i.start && !all_zero) state_d = N_ALIGN;
      N_ALIGN: if (orv[MAG_W-1]) state_d = N_SQ;
      N_SQ:    state_d = N_SUM;
      N_SUM:   state_d = N_SQRT;
      N_SQRT:  if (k_q == '0) state_d = N_DLOAD;
      N_DLOAD: state_d = N_DIV;
      N_DIV: begin
        if (dcnt_q == 4'(QUO_W - 1)) begin
          state_d = (comp_q == 2'd2) ? N_IDLE : N_DLOAD;
        end
      end
      default: state_d = N_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= ((state_q == N_IDLE) && req_i.start && all_zero) ||
                 ((state_q == N_DIV) && (dcnt_q == 4'(QUO_W - 1)) && (comp_q == 2'd2));
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      N_IDLE: begin
        if (req_i.start) begin
          m_q    <= req_i.mag;
          neg_q  <= req_i.neg;
          comp_q <= 2'd0;
          if (all_zero) vec_q <= '0;
        end
      end
      N_ALIGN: begin
        // coarse byte shift, then single bits, until the top bit is set
        for (int i = 0; i < 3; i++) begin
          if (orv[MAG_W-1 -: 8] == '0) begin
            m_q[i] <= m_q[i] << 8;
          end else if (!orv[MAG_W-1]) begin
            m_q[i] <= m_q[i] << 1;
          end
        end
      end
      N_SQ: begin
        for (int i = 0; i < 3; i++) begin
          sq_q[i] <= m_q[i][MAG_W-1 -: TOP_W] * m_q[i][MAG_W-1 -: TOP_W];
        end
      end
      N_SUM: begin
        x_q   <= RAD_W'(sq_q[0]) + RAD_W'(sq_q[1]) + RAD_W'(sq_q[2]);
        res_q <= '0;
        k_q   <= 5'(ROOT_STEPS - 1);
      end
      N_SQRT: begin
        // one result bit per step
        if (take) begin
          x_q   <= x_q - RAD_W'(trial);
          res_q <= (res_q >> 1) + bitv;
        end else begin
          res_q <= res_q >> 1;
        end
        k_q <= k_q - 5'd1;
      end
      N_DLOAD: begin
        rem_q  <= 32'(num[NUM_W-1:FRAC_SH]);
        low_q  <= num[FRAC_SH-1:0];
        quo_q  <= '0;
        dcnt_q <= '0;
      end
      N_DIV: begin
        // restoring division, one quotient bit per step
        rem_q  <= ge ? 32'(dtrial - dvsr) : dtrial[31:0];
        low_q  <= low_q << 1;
        quo_q  <= qfin;
        dcnt_q <= dcnt_q + 4'd1;
        if (dcnt_q == 4'(QUO_W - 1)) begin
          vec_q[comp_q] <= neg_q[comp_q] ? (-qext) : qext;
          comp_q        <= comp_q + 2'd1;
        end
      end
      default: ;
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.vec  = vec_q;

  // a start is only issued to an idle unit
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> (state_q == N_IDLE))
    else $error("normalizer started while busy");

endmodule

### hdl/ttacc_front.sv
// ttacc_front: input stage; accepts items, drops void corners, tags commands
// uses ttacc_pkg; feeds ttacc_queue
`timescale 1ns / 1ps

module ttacc_front import ttacc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                req_type_i,
  input  logic [1:0]          corner_i,
  input  logic [VIDX_W-1:0]   vertex_index_i,
  input  logic signed [31:0]  pos_x_i,
  input  logic signed [31:0]  pos_y_i,
  input  logic signed [31:0]  pos_z_i,
  input  logic signed [31:0]  tex_u_i,
  input  logic signed [31:0]  tex_v_i,
  input  logic                busy_i,
  input  logic                q_full_i,
  output logic                push_o,
  output entry_t              entry_o
);

  logic   f_valid_q, f_valid_d;
  entry_t f_entry_q;
  logic   push, can_load, accept, keep;
  cmd_e   cmd;

  // classify the incoming request
  always_comb begin
    keep = (req_type_i == REQ_READ) || (corner_i != CORNER_VOID);
    if (req_type_i == REQ_READ) begin
      cmd = CMD_READ;
    end else if (corner_i == CORNER_LAST) begin
      cmd = CMD_TRIANGLE;
    end else begin
      cmd = CMD_CORNER;
    end
  end

  // handshake
  always_comb begin
    push       = f_valid_q && !q_full_i;
    can_load   = !f_valid_q || push;
    in_stall_o = busy_i || !can_load;
    accept     = in_valid_i && !in_stall_o;
    if (accept && keep) begin
      f_valid_d = 1'b1;
    end else begin
      f_valid_d = f_valid_q && !push;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else begin
      f_valid_q <= f_valid_d;
    end
  end

  // staged request
  always_ff @(posedge clk_i) begin
    if (accept && keep) begin
      f_entry_q.cmd    <= cmd;
      f_entry_q.corner <= corner_i;
      f_entry_q.idx    <= vertex_index_i;
      f_entry_q.pos    <= {pos_z_i, pos_y_i, pos_x_i};
      f_entry_q.uv     <= {tex_v_i, tex_u_i};
    end
  end

  assign push_o  = push;
  assign entry_o = f_entry_q;

endmodule

### hdl/ttacc_queue.sv
// ttacc_queue: short request fifo between front and back
// uses ttacc_pkg entry type
`timescale 1ns / 1ps

module ttacc_queue import ttacc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output entry_t head_o
);

  entry_t            ent_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;

  function automatic logic [QPTR_W-1:0] ptr_next(logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ptr_next(wr_q);
      if (pop_i)  rd_q <= ptr_next(rd_q);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wr_q] <= entry_i;
  end

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = ent_q[rd_q];

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("request pushed into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("request popped from empty queue");

endmodule

### hdl/ttacc_back.sv
// ttacc_back: triangle engine, corner buffer, vertex store and result register
// uses ttacc_pkg; instantiates ttacc_norm
`timescale 1ns / 1ps

module ttacc_back import ttacc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    q_valid_i,
  input  entry_t  head_i,
  output logic    pop_o,
  output logic    clearing_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t result_o
);

  back_state_e state_q, state_d;

  // corner buffer
  logic [VIDX_W-1:0]              cidx_q [3];
  logic signed [2:0][COORD_W-1:0] cpos_q [3];
  logic signed [1:0][COORD_W-1:0] cuv_q  [3];

  // products
  logic [3:0]               mcnt_q;
  logic signed [DIFF_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_q, acc_q;
  logic signed [ACC_W-1:0]  res_q [7];
  logic [3:0]               pidx;

  logic signed [DIFF_W-1:0] e1 [3];
  logic signed [DIFF_W-1:0] e2 [3];
  logic signed [DIFF_W-1:0] d1u, d1v, d2u, d2v;

  // normalize and update
  vec3_t             tn_q, bn_q, tmp_q;
  logic [1:0]        j_q;
  logic [VADDR_W-1:0] addr_q, addr_d, clr_q, raddr;
  logic              oob_q;
  logic [MEM_W-1:0]  mem_q [VERTEX_COUNT];
  logic [MEM_W-1:0]  rdata_q;
  logic              deg_q;
  logic              out_valid_q;
  result_t           out_q;

  norm_req_t norm_req;
  norm_rsp_t norm_rsp;

  logic               pop, buf_we, addr_we, tn_we, bn_we, tmp_we, j_clr, j_inc;
  logic               mem_we, out_load, deg_set;
  logic [VADDR_W-1:0] mem_waddr;
  logic [MEM_W-1:0]   mem_wdata;
  logic [VIDX_W-1:0]  vidx;

  logic        det_zero, det_neg;
  logic [2:0][MAG_W-1:0] tmag, bmag, stmag, sbmag;
  logic [2:0]            tneg, bneg, stneg, sbneg;
  vec3_t       st_vec, sb_vec;

  ttacc_norm u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (norm_req),
    .rsp_o  (norm_rsp)
  );

  // edges and uv deltas
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1[i] = DIFF_W'($signed(cpos_q[1][i])) - DIFF_W'($signed(cpos_q[0][i]));
      e2[i] = DIFF_W'($signed(cpos_q[2][i])) - DIFF_W'($signed(cpos_q[0][i]));
    end
    d1u = DIFF_W'($signed(cuv_q[1][0])) - DIFF_W'($signed(cuv_q[0][0]));
    d1v = DIFF_W'($signed(cuv_q[1][1])) - DIFF_W'($signed(cuv_q[0][1]));
    d2u = DIFF_W'($signed(cuv_q[2][0])) - DIFF_W'($signed(cuv_q[0][0]));
    d2v = DIFF_W'($signed(cuv_q[2][1])) - DIFF_W'($signed(cuv_q[0][1]));
  end

  // multiplier operand sequence: determinant, tangent, bitangent
  always_comb begin
    case (mcnt_q)
      4'd0:    begin mul_a = d1u; mul_b = d2v;   end
      4'd1:    begin mul_a = d2u; mul_b = d1v;   end
      4'd2:    begin mul_a = d2v; mul_b = e1[0]; end
      4'd3:    begin mul_a = d1v; mul_b = e2[0]; end
      4'd4:    begin mul_a = d2v; mul_b = e1[1]; end
      4'd5:    begin mul_a = d1v; mul_b = e2[1]; end
      4'd6:    begin mul_a = d2v; mul_b = e1[2]; end
      4'd7:    begin mul_a = d1v; mul_b = e2[2]; end
      4'd8:    begin mul_a = d1u; mul_b = e2[0]; end
      4'd9:    begin mul_a = d2u; mul_b = e1[0]; end
      4'd10:   begin mul_a = d1u; mul_b = e2[1]; end
      4'd11:   begin mul_a = d2u; mul_b = e1[1]; end
      4'd12:   begin mul_a = d1u; mul_b = e2[2]; end
      4'd13:   begin mul_a = d2u; mul_b = e1[2]; end
      default: begin mul_a = '0;  mul_b = '0;    end
    endcase
    pidx = mcnt_q - 4'd1;
  end

  // sign and magnitude of new vectors and of store sums
  always_comb begin
    logic [ACC_W-1:0]        tv, bv;
    logic signed [SUM_W-1:0] s;
    logic [SUM_W-1:0]        sm;
    det_zero = (res_q[0] == '0);
    det_neg  = res_q[0][ACC_W-1];
    st_vec   = rdata_q[MEM_W-1 -: 3*VEC_W];
    sb_vec   = rdata_q[3*VEC_W-1:0];
    for (int i = 0; i < 3; i++) begin
      tv = res_q[1+i][ACC_W-1] ? ACC_W'(-res_q[1+i]) : ACC_W'(res_q[1+i]);
      bv = res_q[4+i][ACC_W-1] ? ACC_W'(-res_q[4+i]) : ACC_W'(res_q[4+i]);
      tmag[i] = tv[MAG_W-1:0];
      bmag[i] = bv[MAG_W-1:0];
      tneg[i] = res_q[1+i][ACC_W-1] ^ det_neg;
      bneg[i] = res_q[4+i][ACC_W-1] ^ det_neg;
      s  = SUM_W'($signed(tn_q[i])) + SUM_W'($signed(st_vec[i]));
      sm = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
      stmag[i] = MAG_W'(sm);
      stneg[i] = s[SUM_W-1];
      s  = SUM_W'($signed(bn_q[i])) + SUM_W'($signed(sb_vec[i]));
      sm = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
      sbmag[i] = MAG_W'(sm);
      sbneg[i] = s[SUM_W-1];
    end
  end

  // vertex of the current update step
  always_comb begin
    case (j_q)
      2'd1:    vidx = cidx_q[1];
      2'd2:    vidx = cidx_q[2];
      default: vidx = cidx_q[0];
    endcase
  end

  // sequencer: next state and controls
  always_comb begin
    state_d   = state_q;
    pop       = 1'b0;
    buf_we    = 1'b0;
    addr_we   = 1'b0;
    addr_d    = addr_q;
    tn_we     = 1'b0;
    bn_we     = 1'b0;
    tmp_we    = 1'b0;
    j_clr     = 1'b0;
    j_inc     = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = {tmp_q, norm_rsp.vec};
    out_load  = 1'b0;
    deg_set   = 1'b0;
    norm_req  = '0;
    unique case (state_q)
      B_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        if (clr_q == VADDR_W'(VERTEX_COUNT - 1)) state_d = B_IDLE;
      end
      B_IDLE: begin
        if (q_valid_i) begin
          pop = 1'b1;
          if (head_i.cmd == CMD_READ) begin
            addr_we = 1'b1;
            addr_d  = VADDR_W'(head_i.idx);
            state_d = B_READ_OUT;
          end else begin
            buf_we = 1'b1;
            if (head_i.cmd == CMD_TRIANGLE) state_d = B_MUL;
          end
        end
      end
      B_READ_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = B_IDLE;
        end
      end
      B_MUL: begin
        if (mcnt_q == 4'(MUL_STEPS)) state_d = B_CHECK;
      end
      B_CHECK: begin
        if (det_zero) begin
          deg_set = 1'b1;
          state_d = B_IDLE;
        end else begin
          norm_req = '{start: 1'b1, mag: tmag, neg: tneg};
          state_d  = B_NORM_T;
        end
      end
      B_NORM_T: begin
        if (norm_rsp.done) begin
          tn_we    = 1'b1;
          norm_req = '{start: 1'b1, mag: bmag, neg: bneg};
          state_d  = B_NORM_B;
        end
      end
      B_NORM_B: begin
        if (norm_rsp.done) begin
          bn_we   = 1'b1;
          j_clr   = 1'b1;
          state_d = B_VTX;
        end
      end
      B_VTX: begin
        if (j_q == 2'd3) begin
          state_d = B_IDLE;
        end else if (idx_valid(vidx)) begin
          addr_we = 1'b1;
          addr_d  = VADDR_W'(vidx);
          state_d = B_VTX_CHK;
        end else begin
          j_inc = 1'b1;
        end
      end
      B_VTX_CHK: begin
        if (st_vec == '0) begin
          mem_we    = 1'b1;
          mem_wdata = {tn_q, bn_q};
          j_inc     = 1'b1;
          state_d   = B_VTX;
        end else begin
          norm_req = '{start: 1'b1, mag: stmag, neg: stneg};
          state_d  = B_SUM_T;
        end
      end
      B_SUM_T: begin
        if (norm_rsp.done) begin
          tmp_we   = 1'b1;
          norm_req = '{start: 1'b1, mag: sbmag, neg: sbneg};
          state_d  = B_SUM_B;
        end
      end
      B_SUM_B: begin
        if (norm_rsp.done) begin
          mem_we  = 1'b1;
          j_inc   = 1'b1;
          state_d = B_VTX;
        end
      end
      default: state_d = B_IDLE;
    endcase
    raddr = addr_we ? addr_d : addr_q;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_q       <= '0;
      mcnt_q      <= '0;
      j_q         <= '0;
      deg_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        cidx_q[c] <= '0;
        cpos_q[c] <= '0;
        cuv_q[c]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == B_CLEAR) clr_q <= clr_q + VADDR_W'(1);
      if (state_q == B_MUL) begin
        mcnt_q <= mcnt_q + 4'd1;
      end else begin
        mcnt_q <= '0;
      end
      if (j_clr) begin
        j_q <= '0;
      end else if (j_inc) begin
        j_q <= j_q + 2'd1;
      end
      if (deg_set) deg_q <= 1'b1;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (buf_we) begin
        cidx_q[head_i.corner] <= head_i.idx;
        cpos_q[head_i.corner] <= head_i.pos;
        cuv_q[head_i.corner]  <= head_i.uv;
      end
    end
  end

  // product pipeline: register each product, then fold it in
  always_ff @(posedge clk_i) begin
    if (state_q == B_MUL) begin
      prod_q <= mul_a * mul_b;
      if (mcnt_q != '0) begin
        if (!pidx[0]) begin
          acc_q <= prod_q;
        end else begin
          res_q[pidx[3:1]] <= ACC_W'(acc_q) - ACC_W'(prod_q);
        end
      end
    end
  end

  // vectors, address and result payload
  always_ff @(posedge clk_i) begin
    if (tn_we)  tn_q  <= norm_rsp.vec;
    if (bn_we)  bn_q  <= norm_rsp.vec;
    if (tmp_we) tmp_q <= norm_rsp.vec;
    if (addr_we) begin
      addr_q <= addr_d;
      oob_q  <= !idx_valid(head_i.idx);
    end
    if (out_load) begin
      out_q.tangent    <= oob_q ? '0 : st_vec;
      out_q.binormal   <= oob_q ? '0 : sb_vec;
      out_q.degenerate <= deg_q;
    end
  end

  // vertex store
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    rdata_q <= mem_q[raddr];
  end

  assign pop_o       = pop;
  assign clearing_o  = (state_q == B_CLEAR);
  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

  a_result_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == B_READ_OUT))
    else $error("result raised outside a read");

  a_flag_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(deg_q))
    else $error("degenerate flag cleared");

  a_no_pop_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_CLEAR) |-> (!pop && !out_valid_q))
    else $error("request handled during store clear");

endmodule
